// ===== rtl/core/hgdw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgdw_pkg: shared types and constants of the gather descriptor walker
// result kinds, register indexes, divider and multiplier widths and the
// request/response bundles of the shared divider
// ----------------------------------------------------------------------------
package hgdw_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_FINISH  = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [2:0] REG_STICK_BYTES   = 3'd0;
    localparam logic [2:0] REG_BLOCK_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_BLOCK_STRIDE  = 3'd2;
    localparam logic [2:0] REG_BLOCK_START   = 3'd3;
    localparam logic [2:0] REG_LAYOUT_MODE   = 3'd4;
    localparam logic [2:0] REG_SKIP_UNTILIZE = 3'd5;
    localparam logic [2:0] REG_OUT_BASE      = 3'd6;
    localparam logic [2:0] REG_OWN_XY        = 3'd7;

    // layout modes that pick the block's own coordinate
    localparam logic [1:0] LAYOUT_BLOCK_ROW = 2'd1;
    localparam logic [1:0] LAYOUT_BLOCK_COL = 2'd2;
    localparam logic [1:0] LAYOUT_WIDTH     = 2'd3;

    localparam int BOUND_W = 40;
    localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};

    // shared divider: 16-bit dividend, up to 32-bit divisor
    localparam int DVD_W = 16;
    localparam int DVS_W = 32;

    // shared multiplier: 17-bit by 32-bit
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVD_W-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/hgdw_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgdw_div: shared restoring divider
// one quotient bit per cycle, done pulses in the cycle after the last step
// ----------------------------------------------------------------------------
module hgdw_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hgdw_pkg::div_req_t req,
    output hgdw_pkg::div_rsp_t      rsp
);

    localparam int DvdW = hgdw_pkg::DVD_W;
    localparam int DvsW = hgdw_pkg::DVS_W;
    localparam int CntW = $clog2(DvdW);
    localparam logic [CntW-1:0] LastStep = CntW'(DvdW - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DvdW-1:0] dvd_reg, dvd_next;
    logic [DvdW-1:0] rem_reg, rem_next;
    logic [DvsW-1:0] dvs_reg, dvs_next;

    logic [DvdW:0]   partial;
    logic            fits;
    logic [DvdW:0]   trial;

    // remainder stays below the dividend, so 17 bits carry the shifted value
    assign partial = {rem_reg, dvd_reg[DvdW-1]};
    assign fits    = {{(DvsW-DvdW-1){1'b0}}, partial} >= dvs_reg;
    assign trial   = partial - dvs_reg[DvdW:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DvdW-2:0], fits};
            rem_next = fits ? trial[DvdW-1:0] : partial[DvdW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastStep) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hgdw_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgdw_mul: shared registered multiplier
// 17 x 32 bit product, available the cycle after the operands
// ----------------------------------------------------------------------------
module hgdw_mul (
    input  wire logic                           aclk,
    input  wire logic [hgdw_pkg::MUL_A_W-1:0]   op_a,
    input  wire logic [hgdw_pkg::MUL_B_W-1:0]   op_b,
    output logic      [hgdw_pkg::MUL_P_W-1:0]   prod
);

    logic [hgdw_pkg::MUL_P_W-1:0] prod_reg, prod_next;

    assign prod_next = {{hgdw_pkg::MUL_B_W{1'b0}}, op_a} * {{hgdw_pkg::MUL_A_W{1'b0}}, op_b};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== rtl/core/halo_gather_descriptor_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// halo_gather_descriptor_walker: gather descriptor stream parser
// walks 16-bit descriptor words and issues scatter-write, block release and
// finish commands for a halo gather reader
// ----------------------------------------------------------------------------
// Flow: coordinate, transfer-count, source and destination words are taken
// while idle, with s_ready held high. The segment count word, a zero transfer
// count that ends the stream and the stick-count word drop s_ready while they
// are worked on. The stick-count word of a triple runs through a small
// sequencer around one shared 17x32 multiplier and one shared bit-serial
// divider: a boundary check, then, when the source crosses the block
// boundary, the block step product, a divide by it, the boundary advance and
// a release beat (a zero block step skips the divide and pins the boundary);
// then the modulo of the source by block height (skipped when untilize is
// skipped or the block height is zero), the source and destination stick
// products and the write beat, and a finish beat when the triple ends the
// stream. Each result beat also waits for the output register to be free; the
// output register lets the next word be taken while the last beat of the
// previous one is still held. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module halo_gather_descriptor_walker (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,

    // descriptor words
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_config_word,

    // commands
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_release_count,
    output logic [31:0]      m_src_offset_bytes,
    output logic [7:0]       m_dst_x,
    output logic [7:0]       m_dst_y,
    output logic [31:0]      m_dest_addr,
    output logic [31:0]      m_byte_count,
    output logic             m_last
);

    localparam int BoundW = hgdw_pkg::BOUND_W;
    localparam int ProdW  = hgdw_pkg::MUL_P_W;

    // descriptor parse position
    typedef enum logic [6:0] {
        P_COUNT = 7'h01,
        P_X     = 7'h02,
        P_Y     = 7'h04,
        P_NXFER = 7'h08,
        P_SRC   = 7'h10,
        P_DST   = 7'h20,
        P_SIZE  = 7'h40
    } phase_t;

    // sequencer around the shared units
    typedef enum logic [12:0] {
        S_IDLE  = 13'h0001,
        S_CNT   = 13'h0002,
        S_FIN   = 13'h0004,
        S_CROSS = 13'h0008,
        S_STEP  = 13'h0010,
        S_DIV_N = 13'h0020,
        S_NMUL  = 13'h0040,
        S_NADD  = 13'h0080,
        S_REL   = 13'h0100,
        S_MOD   = 13'h0200,
        S_DIV_M = 13'h0400,
        S_SMUL  = 13'h0800,
        S_WR    = 13'h1000
    } seq_t;

    // configuration registers
    logic [15:0] stick_bytes_reg;
    logic [15:0] block_height_reg;
    logic [15:0] block_stride_reg;
    logic [15:0] block_start_reg;
    logic [1:0]  layout_mode_reg;
    logic        skip_untilize_reg;
    logic [31:0] out_base_reg;
    logic [15:0] own_xy_reg;

    // walker state
    phase_t              phase_reg, phase_next;
    seq_t                state_reg, state_next;
    logic [15:0]         segments_left_reg, segments_left_next;
    logic [15:0]         transfers_left_reg, transfers_left_next;
    logic [7:0]          seg_x_reg, seg_x_next;
    logic [7:0]          seg_y_reg, seg_y_next;
    logic [15:0]         held_src_reg, held_src_next;
    logic [15:0]         held_dst_reg, held_dst_next;
    logic [BoundW-1:0]   boundary_reg, boundary_next;

    // working values of one triple
    logic [15:0]         size_reg, size_next;
    logic [31:0]         step_reg, step_next;
    logic [16:0]         n_reg, n_next;
    logic [15:0]         srcm_reg, srcm_next;
    logic [31:0]         src_off_reg, src_off_next;
    logic [31:0]         dest_addr_reg, dest_addr_next;
    logic                fin_rel_reg, fin_rel_next;
    logic                is_dst_step_reg, is_dst_step_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    hgdw_pkg::kind_t     m_kind_reg, m_kind_next;
    logic [15:0]         m_rel_reg, m_rel_next;
    logic [31:0]         m_src_reg, m_src_next;
    logic [7:0]          m_dx_reg, m_dx_next;
    logic [7:0]          m_dy_reg, m_dy_next;
    logic [31:0]         m_daddr_reg, m_daddr_next;
    logic [31:0]         m_bytes_reg, m_bytes_next;
    logic                m_last_reg, m_last_next;

    // shared units
    hgdw_pkg::div_req_t             div_req;
    hgdw_pkg::div_rsp_t             div_rsp;
    logic [hgdw_pkg::MUL_A_W-1:0]   mul_a;
    logic [hgdw_pkg::MUL_B_W-1:0]   mul_b;
    logic [ProdW-1:0]               prod;

    logic                out_free;
    logic [15:0]         seg_dec;
    logic [15:0]         xfer_dec;
    logic [ProdW:0]      bound_sum;
    logic                crossing;
    logic [7:0]          res_dx;
    logic [7:0]          res_dy;

    hgdw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    hgdw_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_bytes_reg   <= 16'd64;
            block_height_reg  <= 16'd32;
            block_stride_reg  <= 16'd1;
            block_start_reg   <= 16'd0;
            layout_mode_reg   <= 2'd0;
            skip_untilize_reg <= 1'b0;
            out_base_reg      <= 32'd0;
            own_xy_reg        <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hgdw_pkg::REG_STICK_BYTES:   stick_bytes_reg   <= cfg_wdata[15:0];
                hgdw_pkg::REG_BLOCK_HEIGHT:  block_height_reg  <= cfg_wdata[15:0];
                hgdw_pkg::REG_BLOCK_STRIDE:  block_stride_reg  <= cfg_wdata[15:0];
                hgdw_pkg::REG_BLOCK_START:   block_start_reg   <= cfg_wdata[15:0];
                hgdw_pkg::REG_LAYOUT_MODE:   layout_mode_reg   <= cfg_wdata[1:0];
                hgdw_pkg::REG_SKIP_UNTILIZE: skip_untilize_reg <= cfg_wdata[0];
                hgdw_pkg::REG_OUT_BASE:      out_base_reg      <= cfg_wdata;
                hgdw_pkg::REG_OWN_XY:        own_xy_reg        <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign seg_dec   = segments_left_reg - 16'd1;
    assign xfer_dec  = transfers_left_reg - 16'd1;
    // boundary plus blocks times step, one extra bit to see the overflow
    assign bound_sum = {{(ProdW + 1 - BoundW){1'b0}}, boundary_reg} + {1'b0, prod};
    assign crossing  = !skip_untilize_reg && ({{(BoundW-16){1'b0}}, held_src_reg} >= boundary_reg);

    // layout mode picks own x and/or own y instead of the segment's
    assign res_dx = (layout_mode_reg == hgdw_pkg::LAYOUT_BLOCK_ROW ||
                     layout_mode_reg == hgdw_pkg::LAYOUT_WIDTH) ? own_xy_reg[7:0] : seg_x_reg;
    assign res_dy = (layout_mode_reg == hgdw_pkg::LAYOUT_BLOCK_COL ||
                     layout_mode_reg == hgdw_pkg::LAYOUT_WIDTH) ? own_xy_reg[15:8] : seg_y_reg;

    // multiplier operands by sequencer step, product read in the cycle after
    always_comb begin
        unique case (state_reg)
            S_CROSS: begin
                mul_a = {1'b0, block_height_reg};
                mul_b = {16'd0, block_stride_reg};
            end
            S_NMUL: begin
                mul_a = n_reg;
                mul_b = step_reg;
            end
            S_SMUL: begin
                // source offset first, destination stick on the next cycle
                mul_a = is_dst_step_reg ? {1'b0, held_dst_reg} : {1'b0, srcm_reg};
                mul_b = {16'd0, stick_bytes_reg};
            end
            S_WR: begin
                mul_a = {1'b0, size_reg};
                mul_b = {16'd0, stick_bytes_reg};
            end
            default: begin
                // idle: first block boundary is height * (start + 1)
                mul_a = {1'b0, block_height_reg};
                mul_b = {16'd0, block_start_reg};
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        phase_next          = phase_reg;
        state_next          = state_reg;
        segments_left_next  = segments_left_reg;
        transfers_left_next = transfers_left_reg;
        seg_x_next          = seg_x_reg;
        seg_y_next          = seg_y_reg;
        held_src_next       = held_src_reg;
        held_dst_next       = held_dst_reg;
        boundary_next       = boundary_reg;
        size_next           = size_reg;
        step_next           = step_reg;
        n_next              = n_reg;
        srcm_next           = srcm_reg;
        src_off_next        = src_off_reg;
        dest_addr_next      = dest_addr_reg;
        fin_rel_next        = fin_rel_reg;
        is_dst_step_next    = is_dst_step_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_rel_next   = m_rel_reg;
        m_src_next   = m_src_reg;
        m_dx_next    = m_dx_reg;
        m_dy_next    = m_dy_reg;
        m_daddr_next = m_daddr_reg;
        m_bytes_next = m_bytes_reg;
        m_last_next  = m_last_reg;

        div_req = '0;
        s_ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (phase_reg)
                        P_COUNT: begin
                            segments_left_next  = s_config_word;
                            transfers_left_next = 16'd0;
                            state_next          = S_CNT;
                        end
                        P_X: begin
                            seg_x_next = s_config_word[7:0];
                            phase_next = P_Y;
                        end
                        P_Y: begin
                            seg_y_next = s_config_word[7:0];
                            phase_next = P_NXFER;
                        end
                        P_NXFER: begin
                            transfers_left_next = s_config_word;
                            if (s_config_word != 16'd0) begin
                                phase_next = P_SRC;
                            end else begin
                                // empty segment ends at once
                                segments_left_next = seg_dec;
                                if (seg_dec == 16'd0) begin
                                    fin_rel_next = !skip_untilize_reg;
                                    state_next   = S_FIN;
                                end else begin
                                    phase_next = P_X;
                                end
                            end
                        end
                        P_SRC: begin
                            held_src_next = s_config_word;
                            phase_next    = P_DST;
                        end
                        P_DST: begin
                            held_dst_next = s_config_word;
                            phase_next    = P_SIZE;
                        end
                        P_SIZE: begin
                            size_next  = s_config_word;
                            state_next = S_CROSS;
                        end
                        default: phase_next = P_COUNT;
                    endcase
                end
            end

            S_CNT: begin
                boundary_next = BoundW'(block_height_reg) + BoundW'(prod[31:0]);
                if (segments_left_reg == 16'd0) begin
                    // empty stream, no block held yet
                    fin_rel_next = 1'b0;
                    state_next   = S_FIN;
                end else begin
                    phase_next = P_X;
                    state_next = S_IDLE;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = hgdw_pkg::KIND_FINISH;
                    m_rel_next   = {15'd0, fin_rel_reg};
                    m_src_next   = 32'd0;
                    m_dx_next    = 8'd0;
                    m_dy_next    = 8'd0;
                    m_daddr_next = 32'd0;
                    m_bytes_next = 32'd0;
                    m_last_next  = 1'b1;
                    phase_next   = P_COUNT;
                    state_next   = S_IDLE;
                end
            end

            S_CROSS: begin
                state_next = crossing ? S_STEP : S_MOD;
            end

            S_STEP: begin
                step_next = prod[31:0];
                if (prod[31:0] == 32'd0) begin
                    // zero block step: release one block, boundary pinned
                    n_next        = 17'd1;
                    boundary_next = hgdw_pkg::BOUND_MAX;
                    state_next    = S_REL;
                end else begin
                    // source and boundary both sit below 2^16 here
                    div_req.start    = 1'b1;
                    div_req.dividend = held_src_reg - boundary_reg[15:0];
                    div_req.divisor  = prod[31:0];
                    state_next       = S_DIV_N;
                end
            end

            S_DIV_N: begin
                if (div_rsp.done) begin
                    n_next     = {1'b0, div_rsp.quot} + 17'd1;
                    state_next = S_NMUL;
                end
            end

            S_NMUL: begin
                state_next = S_NADD;
            end

            S_NADD: begin
                // saturate the advanced boundary
                if (|bound_sum[ProdW:BoundW]) begin
                    boundary_next = hgdw_pkg::BOUND_MAX;
                end else begin
                    boundary_next = bound_sum[BoundW-1:0];
                end
                state_next = S_REL;
            end

            S_REL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = hgdw_pkg::KIND_RELEASE;
                    m_rel_next   = n_reg[15:0];
                    m_src_next   = 32'd0;
                    m_dx_next    = 8'd0;
                    m_dy_next    = 8'd0;
                    m_daddr_next = 32'd0;
                    m_bytes_next = 32'd0;
                    m_last_next  = 1'b0;
                    state_next   = S_MOD;
                end
            end

            S_MOD: begin
                is_dst_step_next = 1'b0;
                if (!skip_untilize_reg && block_height_reg != 16'd0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = held_src_reg;
                    div_req.divisor  = {16'd0, block_height_reg};
                    state_next       = S_DIV_M;
                end else begin
                    srcm_next  = held_src_reg;
                    state_next = S_SMUL;
                end
            end

            S_DIV_M: begin
                if (div_rsp.done) begin
                    srcm_next  = div_rsp.rem;
                    state_next = S_SMUL;
                end
            end

            S_SMUL: begin
                // two passes: source stick, then destination stick
                if (!is_dst_step_reg) begin
                    is_dst_step_next = 1'b1;
                end else begin
                    src_off_next = prod[31:0];
                    state_next   = S_WR;
                end
            end

            S_WR: begin
                // first cycle here holds the destination product
                if (is_dst_step_reg) begin
                    dest_addr_next   = out_base_reg + prod[31:0];
                    is_dst_step_next = 1'b0;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = hgdw_pkg::KIND_WRITE;
                    m_rel_next   = 16'd0;
                    m_src_next   = src_off_reg;
                    m_dx_next    = res_dx;
                    m_dy_next    = res_dy;
                    m_daddr_next = dest_addr_reg;
                    m_bytes_next = prod[31:0];
                    m_last_next  = 1'b1;
                    transfers_left_next = xfer_dec;
                    state_next          = S_IDLE;
                    if (xfer_dec != 16'd0) begin
                        phase_next = P_SRC;
                    end else begin
                        segments_left_next = seg_dec;
                        if (seg_dec == 16'd0) begin
                            // last transfer of the stream: finish follows
                            m_last_next  = 1'b0;
                            fin_rel_next = !skip_untilize_reg;
                            state_next   = S_FIN;
                        end else begin
                            phase_next = P_X;
                        end
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= P_COUNT;
            state_reg          <= S_IDLE;
            segments_left_reg  <= 16'd0;
            transfers_left_reg <= 16'd0;
            seg_x_reg          <= 8'd0;
            seg_y_reg          <= 8'd0;
            held_src_reg       <= 16'd0;
            held_dst_reg       <= 16'd0;
            boundary_reg       <= '0;
            is_dst_step_reg    <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            state_reg          <= state_next;
            segments_left_reg  <= segments_left_next;
            transfers_left_reg <= transfers_left_next;
            seg_x_reg          <= seg_x_next;
            seg_y_reg          <= seg_y_next;
            held_src_reg       <= held_src_next;
            held_dst_reg       <= held_dst_next;
            boundary_reg       <= boundary_next;
            is_dst_step_reg    <= is_dst_step_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge aclk) begin
        size_reg      <= size_next;
        step_reg      <= step_next;
        n_reg         <= n_next;
        srcm_reg      <= srcm_next;
        src_off_reg   <= src_off_next;
        dest_addr_reg <= dest_addr_next;
        fin_rel_reg   <= fin_rel_next;
        m_kind_reg    <= m_kind_next;
        m_rel_reg     <= m_rel_next;
        m_src_reg     <= m_src_next;
        m_dx_reg      <= m_dx_next;
        m_dy_reg      <= m_dy_next;
        m_daddr_reg   <= m_daddr_next;
        m_bytes_reg   <= m_bytes_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = m_kind_reg;
    assign m_release_count    = m_rel_reg;
    assign m_src_offset_bytes = m_src_reg;
    assign m_dst_x            = m_dx_reg;
    assign m_dst_y            = m_dy_reg;
    assign m_dest_addr        = m_daddr_reg;
    assign m_byte_count       = m_bytes_reg;
    assign m_last             = m_last_reg;

endmodule
`default_nettype wire
